### rtl/rbst_pkg.sv
// rbst_pkg: shared types and constants of the ray/box slab test.
// Fixed field widths, the axis codes and the request and response words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbst_pkg;

   localparam int COORD_BITS = 32;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
   localparam int DIST_BITS  = 31;
   localparam int NUM_AXES   = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type inv_dir_x;
      coord_type inv_dir_y;
      coord_type inv_dir_z;
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [DIST_BITS-1:0] distance;
      logic [1:0]           face_dim;
      logic                 face_negative;
   } rsp_type;

   // per-axis slab result handed to the selection stage
   typedef struct packed {
      coord_type t_near;
      coord_type t_far;
      logic      parallel;
      logic      slab_miss;
      logic      dir_neg;
   } slab_type;

endpackage

`default_nettype wire

### rtl/ray_box_slab_test.sv
// ray_box_slab_test: slab test of one ray against one axis-aligned box.
// Top level: input register, three per-axis slab pipelines, selection stage.
// Depends on rbst_pkg, rbst_slab, rbst_select.
//
// Usage:
//   Request channel: a word on req_word is taken at a rising edge with start
//   high and busy low. busy stays low, so a word can be issued every cycle.
//   Response channel: each request yields exactly one word on rsp_word,
//   marked by rsp_strobe for one cycle. There is no back-pressure; the
//   receiver must take the word in that cycle.
//   Path: a taken word passes the input register and then the difference,
//   multiply, scale and order and select registers; the last drives the
//   response strobe. Throughput: one word per cycle, fixed by the fully
//   pipelined datapath, with two 33 x 32 multipliers per axis in one stage.
//   Words leave in the order they arrived.
//   Reset: synchronous, active high; clears the valid pipeline so no strobe
//   comes out for words in flight. No clearing pass, ready the cycle after.
//   FRAC_BITS sets the fixed-point scaling of the hit distance products.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_test #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rbst_pkg::req_type req_word,
   output rbst_pkg::rsp_type      rsp_word,
   output logic                   rsp_strobe
);

   localparam int LAT = 4;

   rbst_pkg::req_type  req_ff;
   logic [LAT-1:0]     valid_ff, valid_in;
   rbst_pkg::slab_type slab [rbst_pkg::NUM_AXES];

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_word;
   end

   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
      .clock   (clock),
      .origin  (req_ff.origin_x),
      .inv_dir (req_ff.inv_dir_x),
      .box_min (req_ff.box_min_x),
      .box_max (req_ff.box_max_x),
      .slab    (slab[0])
   );

   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
      .clock   (clock),
      .origin  (req_ff.origin_y),
      .inv_dir (req_ff.inv_dir_y),
      .box_min (req_ff.box_min_y),
      .box_max (req_ff.box_max_y),
      .slab    (slab[1])
   );

   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
      .clock   (clock),
      .origin  (req_ff.origin_z),
      .inv_dir (req_ff.inv_dir_z),
      .box_min (req_ff.box_min_z),
      .box_max (req_ff.box_max_z),
      .slab    (slab[2])
   );

   rbst_select u_select (
      .clock      (clock),
      .reset      (reset),
      .valid      (valid_ff[LAT-1]),
      .slab       (slab),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire

### rtl/rbst_slab.sv
// rbst_slab: three-stage pipeline for one axis: corner differences, products with
// the inverse direction, then floor scaling, saturation and near/far ordering.
// Depends on rbst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbst_slab #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire rbst_pkg::coord_type origin,
   input  wire rbst_pkg::coord_type inv_dir,
   input  wire rbst_pkg::coord_type box_min,
   input  wire rbst_pkg::coord_type box_max,
   output rbst_pkg::slab_type       slab
);

   localparam int CB = rbst_pkg::COORD_BITS;
   localparam int DB = rbst_pkg::DIFF_BITS;
   localparam int PB = rbst_pkg::PROD_BITS;

   localparam logic signed [CB-1:0] SENTINEL  = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

   // stage 1: differences
   logic signed [DB-1:0] d_lo_ff, d_lo_in, d_hi_ff, d_hi_in;
   rbst_pkg::coord_type  inv1_ff;
   logic                 par1_ff, miss1_ff, neg1_ff;

   // stage 2: products
   logic signed [PB-1:0] p_lo_ff, p_lo_in, p_hi_ff, p_hi_in;
   logic                 par2_ff, miss2_ff, neg2_ff;

   // stage 3: scaled, ordered distances
   rbst_pkg::slab_type   slab_ff, slab_in;

   function automatic rbst_pkg::coord_type scale_sat(input logic signed [PB-1:0] p);
      logic signed [PB-1:0] s;
      s = p >>> FRAC_BITS;
      if (s > PB'(COORD_MAX))
         return COORD_MAX;
      else if (s < PB'(COORD_MIN))
         return COORD_MIN;
      else
         return s[CB-1:0];
   endfunction

   always_comb begin
      d_lo_in = DB'(box_min) - DB'(origin);
      d_hi_in = DB'(box_max) - DB'(origin);
   end

   always_comb begin
      p_lo_in = PB'(d_lo_ff) * PB'(inv1_ff);
      p_hi_in = PB'(d_hi_ff) * PB'(inv1_ff);
   end

   always_comb begin
      rbst_pkg::coord_type tn, tf;
      tn = scale_sat(p_lo_ff);
      tf = scale_sat(p_hi_ff);
      if (tn > tf) begin
         slab_in.t_near = tf;
         slab_in.t_far  = tn;
      end else begin
         slab_in.t_near = tn;
         slab_in.t_far  = tf;
      end
      slab_in.parallel  = par2_ff;
      slab_in.slab_miss = miss2_ff;
      slab_in.dir_neg   = neg2_ff;
   end

   always_ff @(posedge clock) begin
      d_lo_ff  <= d_lo_in;
      d_hi_ff  <= d_hi_in;
      inv1_ff  <= inv_dir;
      par1_ff  <= (inv_dir == SENTINEL);
      miss1_ff <= (origin < box_min) || (origin > box_max);
      neg1_ff  <= inv_dir[CB-1];
      p_lo_ff  <= p_lo_in;
      p_hi_ff  <= p_hi_in;
      par2_ff  <= par1_ff;
      miss2_ff <= miss1_ff;
      neg2_ff  <= neg1_ff;
      slab_ff  <= slab_in;
   end

   assign slab = slab_ff;

endmodule

`default_nettype wire

### rtl/rbst_select.sv
// rbst_select: merges the three axis slabs into entry/exit bounds, decides hit or
// miss, picks the face and registers the response word and its strobe.
// Depends on rbst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbst_select (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid,
   input  wire rbst_pkg::slab_type slab [rbst_pkg::NUM_AXES],
   output rbst_pkg::rsp_type       rsp_word,
   output logic                    rsp_strobe
);

   rbst_pkg::rsp_type rsp_ff, rsp_in;
   logic              strobe_ff;

   always_comb begin
      rbst_pkg::coord_type t_in, t_out, hit_dist;
      rbst_pkg::axis_type  in_ax, out_ax, fa;
      logic                bounded, miss, outside, neg;
      t_in    = '0;
      t_out   = '0;
      in_ax   = rbst_pkg::AXIS_X;
      out_ax  = rbst_pkg::AXIS_X;
      bounded = 1'b0;
      miss    = 1'b0;
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
         if (slab[a].parallel) begin
            if (slab[a].slab_miss)
               miss = 1'b1;
         end else begin
            // strict compares keep the lower axis on ties
            if (!bounded || slab[a].t_near > t_in) begin
               t_in  = slab[a].t_near;
               in_ax = rbst_pkg::axis_type'(a);
            end
            if (!bounded || slab[a].t_far < t_out) begin
               t_out  = slab[a].t_far;
               out_ax = rbst_pkg::axis_type'(a);
            end
            bounded = 1'b1;
         end
      end
      // bounds only tighten, so checking exit < entry once at the end suffices
      if (t_out < t_in || t_out < 0 || !bounded)
         miss = 1'b1;
      outside  = t_in > 0;
      fa       = outside ? in_ax : out_ax;
      hit_dist = outside ? t_in : t_out;
      neg      = outside ? !slab[fa].dir_neg : slab[fa].dir_neg;
      if (miss) begin
         rsp_in = '0;
      end else begin
         rsp_in.hit           = 1'b1;
         rsp_in.distance      = hit_dist[rbst_pkg::DIST_BITS-1:0];
         rsp_in.face_dim      = fa;
         rsp_in.face_negative = neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_word   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

### verif/ray_box_slab_checker.sv
// ray_box_slab_checker: predicts the response word of every accepted request word and
// compares it field by field with the word the block returns. Depends on rbst_pkg.
`timescale 1ns / 1ps

module ray_box_slab_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  rbst_pkg::req_type req_word,
   input  rbst_pkg::rsp_type rsp_word,
   input  logic              rsp_strobe,
   output int                fail_count,
   output int                outstanding
);

   localparam int CB = rbst_pkg::COORD_BITS;
   localparam int NA = rbst_pkg::NUM_AXES;
   localparam rbst_pkg::coord_type AXIS_PARALLEL = {1'b1, {(CB-1){1'b0}}};

   rbst_pkg::rsp_type predicted_rsp[$];
   int                mismatches = 0;

   // (corner - origin) * inv, floored to FRAC_BITS and saturated to the coordinate range
   function automatic rbst_pkg::coord_type slab_distance(input rbst_pkg::coord_type corner,
                                                         input rbst_pkg::coord_type origin,
                                                         input rbst_pkg::coord_type inv);
      logic signed [CB:0] delta;
      logic signed [95:0] prod, top_lim, bot_lim;
      delta   = corner;
      delta   = delta - origin;
      prod    = 96'(delta) * 96'(inv);
      prod    = prod >>> FRAC_BITS;
      top_lim = (longint'(1) <<< (CB - 1)) - 1;
      bot_lim = -top_lim - 1;
      if (prod > top_lim) return rbst_pkg::coord_type'(top_lim);
      if (prod < bot_lim) return rbst_pkg::coord_type'(bot_lim);
      return rbst_pkg::coord_type'(prod);
   endfunction

   function automatic rbst_pkg::rsp_type predict_hit(input rbst_pkg::req_type r);
      rbst_pkg::coord_type org[NA], inv[NA], lo[NA], hi[NA];
      rbst_pkg::coord_type tn, tf, t_in, t_out, hit_dist;
      rbst_pkg::axis_type  in_axis, out_axis, face;
      logic                bounded, miss, outside, neg;
      rbst_pkg::rsp_type   res;
      org      = '{r.origin_x, r.origin_y, r.origin_z};
      inv      = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
      lo       = '{r.box_min_x, r.box_min_y, r.box_min_z};
      hi       = '{r.box_max_x, r.box_max_y, r.box_max_z};
      bounded  = 1'b0;
      miss     = 1'b0;
      t_in     = '0;
      t_out    = '0;
      in_axis  = rbst_pkg::AXIS_X;
      out_axis = rbst_pkg::AXIS_X;
      res      = '0;
      for (int a = 0; a < NA; a++) begin
         if (inv[a] == AXIS_PARALLEL) begin
            if (org[a] < lo[a] || org[a] > hi[a]) miss = 1'b1;
         end else begin
            tn = slab_distance(lo[a], org[a], inv[a]);
            tf = slab_distance(hi[a], org[a], inv[a]);
            if (tn > tf) {tn, tf} = {tf, tn};
            // strict compares keep the lower axis on ties
            if (!bounded || tn > t_in) begin
               t_in    = tn;
               in_axis = rbst_pkg::axis_type'(a);
            end
            if (!bounded || tf < t_out) begin
               t_out    = tf;
               out_axis = rbst_pkg::axis_type'(a);
            end
            bounded = 1'b1;
            if (t_out < t_in) miss = 1'b1;
         end
      end
      if (!miss && bounded && t_out >= 0) begin
         outside  = t_in > 0;
         face     = outside ? in_axis : out_axis;
         hit_dist = outside ? t_in : t_out;
         neg      = inv[face] >= 0;
         if (!outside) neg = !neg;
         res.hit           = 1'b1;
         res.distance      = hit_dist[rbst_pkg::DIST_BITS-1:0];
         res.face_dim      = face;
         res.face_negative = neg;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rbst_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (predicted_rsp.size() == 0) begin
               $error("response word with no request outstanding: %0h", rsp_word);
               mismatches++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_word.hit !== want.hit) begin
                  $error("hit: expected %0h, got %0h", want.hit, rsp_word.hit);
                  mismatches++;
               end
               if (rsp_word.distance !== want.distance) begin
                  $error("distance: expected %0h, got %0h", want.distance, rsp_word.distance);
                  mismatches++;
               end
               if (rsp_word.face_dim !== want.face_dim) begin
                  $error("face_dim: expected %0h, got %0h", want.face_dim,
                         rsp_word.face_dim);
                  mismatches++;
               end
               if (rsp_word.face_negative !== want.face_negative) begin
                  $error("face_negative: expected %0h, got %0h", want.face_negative,
                         rsp_word.face_negative);
                  mismatches++;
               end
            end
         end
         if (start && !busy) predicted_rsp.push_back(predict_hit(req_word));
      end
      outstanding <= predicted_rsp.size();
      fail_count  <= mismatches;
   end

endmodule

### verif/ray_box_slab_test_tb.sv
// ray_box_slab_test_tb: drives directed and random ray/box request words into the block
// with random sender gaps, none in the last random phase, and gives the verdict. Depends
// on rbst_pkg, ray_box_slab_test, ray_box_slab_checker.
`timescale 1ns / 1ps

module ray_box_slab_test_tb;

   localparam int                  FRAC_BITS     = 16;
   localparam int                  CB            = rbst_pkg::COORD_BITS;
   localparam int                  NA            = rbst_pkg::NUM_AXES;
   localparam int                  ONE           = 1 << FRAC_BITS;
   localparam int                  QUIET_LIMIT   = 2000;
   localparam int                  NUM_FIELDS    = $bits(rbst_pkg::req_type) / CB;
   localparam rbst_pkg::coord_type AXIS_PARALLEL = 32'h8000_0000;
   localparam rbst_pkg::coord_type COORD_MAX     = 32'h7FFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   rbst_pkg::req_type req_word = '0;
   logic              busy;
   rbst_pkg::rsp_type rsp_word;
   logic              rsp_strobe;
   int                fail_count;
   int                outstanding;
   int                quiet = 0;

   always #6 clock = ~clock;

   ray_box_slab_test #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_word(rsp_word),
      .rsp_strobe(rsp_strobe)
   );

   ray_box_slab_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_word(rsp_word),
      .rsp_strobe(rsp_strobe),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("** ray_box_slab_test: FAILED **");
         $finish;
      end
   end

   function automatic rbst_pkg::req_type ray_word(input rbst_pkg::coord_type ox, oy, oz,
                                                  ix, iy, iz, lx, ly, lz, hx, hy, hz);
      return rbst_pkg::req_type'({ox, oy, oz, ix, iy, iz, lx, ly, lz, hx, hy, hz});
   endfunction

   function automatic longint rand_span(input longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   // returns at the edge that takes the word; start stays high
   task automatic send_word(input rbst_pkg::req_type w, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int count);
      rbst_pkg::req_type                    w;
      logic [$bits(rbst_pkg::req_type)-1:0] raw;
      rbst_pkg::coord_type                  o[NA], iv[NA], lo[NA], hi[NA];
      longint                               ctr, half, tgt, org, dir, inv;
      int                                   kind, mode;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            // noise: raw bits, some fields forced to extremes
            for (int f = 0; f < NUM_FIELDS; f++) begin
               if (kind < 8 || $urandom_range(1)) begin
                  raw[f*CB +: CB] = $urandom;
               end else begin
                  case ($urandom_range(4))
                     0: raw[f*CB +: CB] = AXIS_PARALLEL;
                     1: raw[f*CB +: CB] = COORD_MAX;
                     2: raw[f*CB +: CB] = '0;
                     3: raw[f*CB +: CB] = 1;
                     default: raw[f*CB +: CB] = '1;
                  endcase
               end
            end
            w = rbst_pkg::req_type'(raw);
         end else begin
            for (int a = 0; a < NA; a++) begin
               ctr  = rand_span(50 * ONE);
               half = 4096 + $urandom_range(20 * ONE);
               if (kind < 40) begin
                  // origin inside the box
                  org = ctr + rand_span(half);
                  tgt = org + rand_span(100 * ONE);
               end else if (kind < 85) begin
                  // aimed at a point in the box
                  tgt = ctr + rand_span(half);
                  org = tgt + rand_span(100 * ONE);
               end else begin
                  tgt = rand_span(100 * ONE);
                  org = rand_span(100 * ONE);
               end
               mode = $urandom_range(19);
               if (mode == 0) begin
                  iv[a] = AXIS_PARALLEL;
                  if (kind >= 40 && kind < 85) org = tgt;
               end else if (mode == 1) begin
                  iv[a] = '0;
               end else begin
                  dir = tgt - org;
                  if (dir == 0) dir = 1;
                  inv = (longint'(1) <<< (2 * FRAC_BITS)) / dir;
                  if (inv > longint'(COORD_MAX)) inv = longint'(COORD_MAX);
                  else if (inv <= longint'(AXIS_PARALLEL)) inv = longint'(AXIS_PARALLEL) + 1;
                  iv[a] = rbst_pkg::coord_type'(inv);
               end
               o[a] = rbst_pkg::coord_type'(org);
               if (mode == 2) begin
                  lo[a] = rbst_pkg::coord_type'(ctr + half);
                  hi[a] = rbst_pkg::coord_type'(ctr - half);
               end else begin
                  lo[a] = rbst_pkg::coord_type'(ctr - half);
                  hi[a] = rbst_pkg::coord_type'(ctr + half);
               end
            end
            w = ray_word(o[0], o[1], o[2], iv[0], iv[1], iv[2],
                         lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         end
         send_word(w, idle_pct);
      end
   endtask

   initial begin
      rbst_pkg::req_type drill[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // along +x and -x from outside
      drill.push_back(ray_word(-5*ONE, 0, 0, ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      drill.push_back(ray_word(5*ONE, 0, 0, -ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // parallel axis with origin outside its slab
      drill.push_back(ray_word(-5*ONE, 3*ONE, 0, ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // no bounded axis
      drill.push_back(ray_word(0, 0, 0, AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // inside, exit tie on all axes
      drill.push_back(ray_word(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // box behind origin
      drill.push_back(ray_word(5*ONE, 0, 0, ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // exit before entry
      drill.push_back(ray_word(-5*ONE, -5*ONE, 0, ONE, ONE, AXIS_PARALLEL,
                               -ONE, 3*ONE, -ONE, ONE, 4*ONE, ONE));
      // entry ties
      drill.push_back(ray_word(-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      drill.push_back(ray_word(0, -3*ONE, -3*ONE, AXIS_PARALLEL, ONE, ONE,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // zero inverse direction
      drill.push_back(ray_word(-5*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      drill.push_back(ray_word(0, 0, 0, 0, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      // positive and negative saturation
      drill.push_back(ray_word(AXIS_PARALLEL, 0, 0, COORD_MAX, AXIS_PARALLEL, AXIS_PARALLEL,
                               32'h7FFF_0000, -ONE, -ONE, COORD_MAX, ONE, ONE));
      drill.push_back(ray_word(AXIS_PARALLEL, 0, 0, 32'h8000_0001, AXIS_PARALLEL,
                               AXIS_PARALLEL, 32'h7FFF_0000, -ONE, -ONE, COORD_MAX, ONE, ONE));
      // inverted box
      drill.push_back(ray_word(-5*ONE, 0, 0, ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               ONE, -ONE, -ONE, -ONE, ONE, ONE));
      // floor of a negative product with fraction bits
      drill.push_back(ray_word(0, 0, 0, -3, AXIS_PARALLEL, AXIS_PARALLEL,
                               1, -ONE, -ONE, 5*ONE, ONE, ONE));
      // field extremes
      drill.push_back('0);
      drill.push_back(ray_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX));
      drill.push_back(ray_word(AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL,
                               AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL,
                               AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL, AXIS_PARALLEL));
      drill.push_back('1);
      // y face from outside, z face from inside, origin on a face
      drill.push_back(ray_word(0, 5*ONE, 0, AXIS_PARALLEL, -ONE, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      drill.push_back(ray_word(0, 0, 0, AXIS_PARALLEL, AXIS_PARALLEL, -ONE,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));
      drill.push_back(ray_word(-ONE, 0, 0, ONE, AXIS_PARALLEL, AXIS_PARALLEL,
                               -ONE, -ONE, -ONE, ONE, ONE, ONE));

      foreach (drill[i]) send_word(drill[i], 28);

      run_phase(28, 470);
      drain();
      run_phase(71, 470);
      drain();
      run_phase(0, 460);
      drain();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("** ray_box_slab_test: PASSED **");
      end else begin
         $display("** ray_box_slab_test: FAILED **");
      end
      $finish;
   end

endmodule
